### rtl/osc_pkg.sv
// shared constants and types for the obstacle steering controller
package osc_pkg;

    // field widths
    localparam int DIST_WIDTH   = 16;
    localparam int PERIOD_WIDTH = 24;
    localparam int REG_WIDTH    = 8;

    // derived datapath widths
    localparam int RT_W   = DIST_WIDTH + 1;          // trimmed right distance
    localparam int SUM_W  = DIST_WIDTH + 2;          // r + l
    localparam int NUM_W  = SUM_W + 10;              // signed duty numerator
    localparam int DEN_W  = SUM_W + 8;               // 200 * (r + l)
    localparam int PROD_W = DEN_W + PERIOD_WIDTH;    // numerator * period
    localparam int CNT_W  = $clog2(PERIOD_WIDTH + 1);

    // arithmetic constants
    localparam int VALID_MAX    = 255;
    localparam int PCT_SCALE    = 100;
    localparam int HALF_PCT_DEN = 200;

    // configuration register reset values
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST = PERIOD_WIDTH'(153600);
    localparam logic [REG_WIDTH-1:0]    STOP_RST   = 8'd15;
    localparam logic [REG_WIDTH-1:0]    LOW_RST    = 8'd5;
    localparam logic [REG_WIDTH-1:0]    TRIM_RST   = 8'd5;
    localparam logic [REG_WIDTH-1:0]    CENTER_RST = 8'd145;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_PWM_PERIOD    = 3'd0,
        REG_STOP_DISTANCE = 3'd1,
        REG_SIDE_LOW      = 3'd2,
        REG_RIGHT_TRIM    = 3'd3,
        REG_CENTER        = 3'd4
    } reg_idx_t;

endpackage

### rtl/osc_if.sv
// valid/ready channel interfaces for sonar input beats and steering result beats
interface osc_in_if;
    import osc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] left_distance;
    logic [DIST_WIDTH-1:0] right_distance;
    logic [DIST_WIDTH-1:0] front_distance;

    modport source (output valid, output left_distance, output right_distance,
                    output front_distance, input ready);
    modport sink   (input valid, input left_distance, input right_distance,
                    input front_distance, output ready);
endinterface

interface osc_out_if;
    import osc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PERIOD_WIDTH-1:0] servo_compare;
    logic                    drive_forward;
    logic                    fault;

    modport source (output valid, output servo_compare, output drive_forward,
                    output fault, input ready);
    modport sink   (input valid, input servo_compare, input drive_forward,
                    input fault, output ready);
endinterface

### rtl/osc_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit the period width
module osc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [osc_pkg::PROD_W-1:0]    dividend,
    input  logic [osc_pkg::DEN_W-1:0]     divisor,
    output logic                          done,
    output logic [osc_pkg::PERIOD_WIDTH-1:0] quotient
);
    import osc_pkg::*;

    logic [DEN_W-1:0]        rem_reg;
    logic [DEN_W-1:0]        rem_next;
    logic [PERIOD_WIDTH-1:0] lo_reg;
    logic [PERIOD_WIDTH-1:0] lo_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [DEN_W:0]          trial;
    logic                    ge;

    // one trial subtraction per step
    always_comb
    begin
        trial = {rem_reg, lo_reg[PERIOD_WIDTH-1]};
        ge    = (trial >= {1'b0, divisor});
    end

    // step sequencing
    always_comb
    begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[PROD_W-1:PERIOD_WIDTH];
            lo_next   = dividend[PERIOD_WIDTH-1:0];
            cnt_next  = CNT_W'(PERIOD_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, divisor}) : DEN_W'(trial);
            lo_next  = {lo_reg[PERIOD_WIDTH-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

### rtl/osc_cfg.sv
// configuration register file for period, thresholds, trim and center duty
module osc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [osc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [osc_pkg::PERIOD_WIDTH-1:0] cfg_data,
    output logic [osc_pkg::PERIOD_WIDTH-1:0] pwm_period,
    output logic [osc_pkg::REG_WIDTH-1:0]    stop_distance,
    output logic [osc_pkg::REG_WIDTH-1:0]    side_low_distance,
    output logic [osc_pkg::REG_WIDTH-1:0]    right_trim,
    output logic [osc_pkg::REG_WIDTH-1:0]    center_half_percent
);
    import osc_pkg::*;

    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [REG_WIDTH-1:0]    stop_reg;
    logic [REG_WIDTH-1:0]    low_reg;
    logic [REG_WIDTH-1:0]    trim_reg;
    logic [REG_WIDTH-1:0]    center_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            stop_reg   <= STOP_RST;
            low_reg    <= LOW_RST;
            trim_reg   <= TRIM_RST;
            center_reg <= CENTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PWM_PERIOD:    period_reg <= cfg_data;
                REG_STOP_DISTANCE: stop_reg   <= cfg_data[REG_WIDTH-1:0];
                REG_SIDE_LOW:      low_reg    <= cfg_data[REG_WIDTH-1:0];
                REG_RIGHT_TRIM:    trim_reg   <= cfg_data[REG_WIDTH-1:0];
                REG_CENTER:        center_reg <= cfg_data[REG_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    assign pwm_period          = period_reg;
    assign stop_distance       = stop_reg;
    assign side_low_distance   = low_reg;
    assign right_trim          = trim_reg;
    assign center_half_percent = center_reg;

endmodule

### rtl/obstacle_steering_controller_core.sv
// obstacle steering controller top level: sequencer, duty datapath and result register
//
// Usage
//   sonar : sink channel, one beat carries left, right and front distances
//   steer : source channel, one beat carries servo_compare, drive_forward
//           and fault for each sonar beat, in order
//   cfg_we/cfg_index/cfg_data : register writes, taken at any edge with
//           cfg_we high; write only while no sonar beat is in flight
// Sequencing
//   a result goes through CHECK and FINISH on a fault, through CHECK, SCALE
//   and FINISH on a clamped duty, and also through LAUNCH and DIVIDE when the
//   compare value needs the divide, the restoring divider giving one quotient bit per cycle
//   sonar.ready is high only while the sequencer is idle, one beat at a
//   time, so a new beat is taken only once the last result is in the output register
// Reset
//   registers return to their defaults, the validity check is disarmed
//   until the first beat, no result is pending
// Stall
//   a finished result waits in the output register; the next sonar beat
//   is taken meanwhile and its result waits until that register drains
module obstacle_steering_controller_core (
    input  logic                             clk,
    input  logic                             rst_n,
    osc_in_if.sink                           sonar,
    osc_out_if.source                        steer,
    input  logic                             cfg_we,
    input  logic [osc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [osc_pkg::PERIOD_WIDTH-1:0] cfg_data
);
    import osc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCALE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // configuration
    logic [PERIOD_WIDTH-1:0] pwm_period;
    logic [REG_WIDTH-1:0]    stop_distance;
    logic [REG_WIDTH-1:0]    side_low_distance;
    logic [REG_WIDTH-1:0]    right_trim;
    logic [REG_WIDTH-1:0]    center_half_percent;

    // sequencer and working registers
    state_t                  state_reg, state_next;
    logic                    primed_reg, primed_next;
    logic [DIST_WIDTH-1:0]   left_reg, right_reg, front_reg;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [PERIOD_WIDTH-1:0] res_cmp_reg, res_cmp_next;
    logic                    res_drive_reg, res_drive_next;
    logic                    res_fault_reg, res_fault_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [PERIOD_WIDTH-1:0] out_cmp_reg;
    logic                    out_drive_reg;
    logic                    out_fault_reg;
    logic                    out_load;

    // divider
    logic                    div_start;
    logic                    div_done;
    logic [PERIOD_WIDTH-1:0] div_quot;

    // check stage signals
    logic                    invalid;
    logic [RT_W-1:0]         r_trim;
    logic [SUM_W-1:0]        side_sum;
    logic [SUM_W+7:0]        center_prod;
    logic                    centered;
    logic signed [NUM_W-1:0] steer_num;

    // scale stage signals
    logic                    num_nonpos;
    logic                    num_full;

    osc_cfg u_cfg (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .pwm_period          (pwm_period),
        .stop_distance       (stop_distance),
        .side_low_distance   (side_low_distance),
        .right_trim          (right_trim),
        .center_half_percent (center_half_percent)
    );

    osc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // reading validity and steering numerator
    always_comb
    begin
        invalid = (left_reg == '0) || (left_reg > DIST_WIDTH'(VALID_MAX)) ||
                  (right_reg == '0) || (right_reg > DIST_WIDTH'(VALID_MAX)) ||
                  (front_reg == '0) || (front_reg > DIST_WIDTH'(VALID_MAX));
        r_trim      = RT_W'(right_reg) + RT_W'(right_trim);
        side_sum    = SUM_W'(r_trim) + SUM_W'(left_reg);
        center_prod = (SUM_W+8)'(center_half_percent) * (SUM_W+8)'(side_sum);
        centered    = ((r_trim < RT_W'(side_low_distance)) &&
                       (left_reg < DIST_WIDTH'(side_low_distance))) ||
                      (r_trim == RT_W'(left_reg)) ||
                      (front_reg < DIST_WIDTH'(stop_distance));
        steer_num   = $signed(NUM_W'(center_prod) +
                              NUM_W'(r_trim) * NUM_W'(PCT_SCALE) -
                              NUM_W'(left_reg) * NUM_W'(PCT_SCALE));
    end

    // duty clamps
    always_comb
    begin
        num_nonpos = num_reg[NUM_W-1] || (num_reg == '0);
        num_full   = (num_reg >= $signed(NUM_W'(den_reg)));
    end

    assign div_start = (state_reg == ST_LAUNCH);
    assign out_load  = !out_valid_reg || steer.ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        primed_next    = primed_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        prod_next      = prod_reg;
        res_cmp_next   = res_cmp_reg;
        res_drive_next = res_drive_reg;
        res_fault_next = res_fault_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && steer.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (sonar.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (primed_reg && invalid)
                begin
                    primed_next    = 1'b0;
                    res_cmp_next   = '0;
                    res_drive_next = 1'b0;
                    res_fault_next = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    primed_next    = 1'b1;
                    res_fault_next = 1'b0;
                    res_drive_next = !(front_reg < DIST_WIDTH'(stop_distance));
                    if (centered)
                    begin
                        num_next = $signed(NUM_W'(center_half_percent));
                        den_next = DEN_W'(HALF_PCT_DEN);
                    end
                    else
                    begin
                        num_next = steer_num;
                        den_next = DEN_W'(side_sum) * DEN_W'(HALF_PCT_DEN);
                    end
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                prod_next = PROD_W'(num_reg[DEN_W-1:0]) * PROD_W'(pwm_period);
                if (num_nonpos || (pwm_period == '0))
                begin
                    res_cmp_next = '0;
                    state_next   = ST_FINISH;
                end
                else if (num_full)
                begin
                    res_cmp_next = pwm_period;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_cmp_next = div_quot;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            primed_reg    <= primed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && sonar.valid)
        begin
            left_reg  <= sonar.left_distance;
            right_reg <= sonar.right_distance;
            front_reg <= sonar.front_distance;
        end
        num_reg       <= num_next;
        den_reg       <= den_next;
        prod_reg      <= prod_next;
        res_cmp_reg   <= res_cmp_next;
        res_drive_reg <= res_drive_next;
        res_fault_reg <= res_fault_next;
        if ((state_reg == ST_FINISH) && out_load)
        begin
            out_cmp_reg   <= res_cmp_reg;
            out_drive_reg <= res_drive_reg;
            out_fault_reg <= res_fault_reg;
        end
    end

    // channel outputs
    assign sonar.ready         = (state_reg == ST_IDLE);
    assign steer.valid         = out_valid_reg;
    assign steer.servo_compare = out_cmp_reg;
    assign steer.drive_forward = out_drive_reg;
    assign steer.fault         = out_fault_reg;

endmodule

### rtl/osc_checker.sv
// port-level checks for the obstacle steering controller, bound to the top level
module osc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [osc_pkg::PERIOD_WIDTH-1:0] servo_compare,
    input logic                             drive_forward,
    input logic                             fault
);
    import osc_pkg::*;

    // one beat at a time: busy right after a sonar beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sonar beat accepted while a beat is in flight");

    // no result appears in the cycle right after a sonar beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result beat raised too early");

    // a fault beat stops the drive and parks the servo at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault |-> (servo_compare == '0) && !drive_forward)
        else $error("fault beat with live steering values");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(servo_compare) &&
            $stable(drive_forward) && $stable(fault))
        else $error("stalled result beat changed");

endmodule

bind obstacle_steering_controller_core osc_checker u_osc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sonar.valid),
    .in_ready      (sonar.ready),
    .out_valid     (steer.valid),
    .out_ready     (steer.ready),
    .servo_compare (steer.servo_compare),
    .drive_forward (steer.drive_forward),
    .fault         (steer.fault)
);

### dv/obstacle_steering_controller_core_tb.sv
// testbench for the obstacle steering controller: sonar beats in, steering beats checked
module obstacle_steering_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import osc_pkg::*;

    localparam int DIST_MAX     = (1 << DIST_WIDTH) - 1;
    localparam int PERIOD_MAX   = (1 << PERIOD_WIDTH) - 1;
    localparam int REG_MAX      = (1 << REG_WIDTH) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 210;
    localparam int RANDOM_PHASES = 8;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] servo_compare;
        logic                    drive_forward;
        logic                    fault;
    } steer_beat_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [REG_IDX_W-1:0]    cfg_index;
    logic [PERIOD_WIDTH-1:0] cfg_data;

    osc_in_if  sonar_ch ();
    osc_out_if steer_ch ();

    obstacle_steering_controller_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sonar     (sonar_ch),
        .steer     (steer_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the registers and the validity arm
    logic [PERIOD_WIDTH-1:0] period_reg;
    logic [REG_WIDTH-1:0]    stop_reg;
    logic [REG_WIDTH-1:0]    side_low_reg;
    logic [REG_WIDTH-1:0]    trim_reg;
    logic [REG_WIDTH-1:0]    center_reg;
    bit                      armed;

    steer_beat_t pending_steer[$];
    int          mismatch_count;
    int          idle_cycles;
    bit          steady_mode;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // random gap: mostly none or short, a few long
    function automatic int unsigned rand_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // compare value for a duty of num/den half-percent, clamped to the period
    function automatic logic [PERIOD_WIDTH-1:0] compare_for_duty(longint num, longint den);
        longint lim;
        if (num <= 0 || period_reg == 0)
            return '0;
        lim = HALF_PCT_DEN * den;
        if (num >= lim)
            return period_reg;
        return PERIOD_WIDTH'((num * longint'(period_reg)) / lim);
    endfunction

    // expected steering beat for one sonar beat, advances the arm state
    function automatic steer_beat_t predict_steering(logic [DIST_WIDTH-1:0] l,
                                                     logic [DIST_WIDTH-1:0] r,
                                                     logic [DIST_WIDTH-1:0] f);
        steer_beat_t beat;
        longint      lt;
        longint      rt;
        longint      sum;
        longint      num;
        beat = '0;
        if (armed && (l == 0 || l > VALID_MAX || r == 0 || r > VALID_MAX ||
                      f == 0 || f > VALID_MAX))
        begin
            armed = 1'b0;
            beat.fault = 1'b1;
            return beat;
        end
        armed = 1'b1;
        lt = longint'(l);
        rt = longint'(r) + longint'(trim_reg);
        if ((rt < longint'(side_low_reg) && lt < longint'(side_low_reg)) || rt == lt)
            beat.servo_compare = compare_for_duty(longint'(center_reg), 1);
        else
        begin
            sum = rt + lt;
            num = longint'(center_reg) * sum + PCT_SCALE * rt - PCT_SCALE * lt;
            beat.servo_compare = compare_for_duty(num, sum);
        end
        // front stop overrides steering
        if (longint'(f) < longint'(stop_reg))
        begin
            beat.drive_forward = 1'b0;
            beat.servo_compare = compare_for_duty(longint'(center_reg), 1);
        end
        else
            beat.drive_forward = 1'b1;
        return beat;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // send one sonar beat, predict its result on acceptance
    task automatic send_reading(logic [DIST_WIDTH-1:0] l, logic [DIST_WIDTH-1:0] r,
                                logic [DIST_WIDTH-1:0] f);
        int unsigned gap;
        gap = steady_mode ? 0 : rand_gap();
        if (gap > 0)
        begin
            sonar_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sonar_ch.valid          <= 1'b1;
        sonar_ch.left_distance  <= l;
        sonar_ch.right_distance <= r;
        sonar_ch.front_distance <= f;
        do
            @(posedge clk);
        while (!sonar_ch.ready);
        pending_steer.push_back(predict_steering(l, r, f));
        @(negedge clk);
    endtask

    // let every expected beat arrive and the sequencer settle
    task automatic wait_drained();
        sonar_ch.valid <= 1'b0;
        while (pending_steer.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one register write, mirrored into the shadow copy
    task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [PERIOD_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (index)
            REG_PWM_PERIOD:    period_reg   = value;
            REG_STOP_DISTANCE: stop_reg     = value[REG_WIDTH-1:0];
            REG_SIDE_LOW:      side_low_reg = value[REG_WIDTH-1:0];
            REG_RIGHT_TRIM:    trim_reg     = value[REG_WIDTH-1:0];
            REG_CENTER:        center_reg   = value[REG_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(int unsigned period, int unsigned stop, int unsigned low,
                                int unsigned trim, int unsigned center);
        wait_drained();
        write_reg(REG_PWM_PERIOD, PERIOD_WIDTH'(period));
        write_reg(REG_STOP_DISTANCE, PERIOD_WIDTH'(stop));
        write_reg(REG_SIDE_LOW, PERIOD_WIDTH'(low));
        write_reg(REG_RIGHT_TRIM, PERIOD_WIDTH'(trim));
        write_reg(REG_CENTER, PERIOD_WIDTH'(center));
    endtask

    function automatic logic [DIST_WIDTH-1:0] good_distance();
        case ($urandom_range(0, 3))
            0:       return DIST_WIDTH'($urandom_range(1, 20));
            1:       return DIST_WIDTH'($urandom_range(1, 60));
            default: return DIST_WIDTH'($urandom_range(1, VALID_MAX));
        endcase
    endfunction

    function automatic logic [DIST_WIDTH-1:0] bad_distance();
        if ($urandom_range(0, 2) == 0)
            return '0;
        return DIST_WIDTH'($urandom_range(VALID_MAX + 1, DIST_MAX));
    endfunction

    // mostly valid readings, some with one bad field, some raw noise, some balanced after trim
    task automatic send_random_reading();
        logic [DIST_WIDTH-1:0] l;
        logic [DIST_WIDTH-1:0] r;
        logic [DIST_WIDTH-1:0] f;
        int unsigned           pick;
        l    = good_distance();
        r    = good_distance();
        f    = good_distance();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            case ($urandom_range(0, 2))
                0:       l = bad_distance();
                1:       r = bad_distance();
                default: f = bad_distance();
            endcase
        end
        else if (pick < 11)
        begin
            l = DIST_WIDTH'($urandom);
            r = DIST_WIDTH'($urandom);
            f = DIST_WIDTH'($urandom);
        end
        else if (pick < 17 && l > trim_reg)
            r = l - DIST_WIDTH'(trim_reg);
        send_reading(l, r, f);
    endtask

    // reset values, faults on each field, unchecked first beats, front stop edge
    task automatic test_reset_defaults();
        send_reading(DIST_MAX, DIST_MAX, DIST_MAX);
        send_reading(VALID_MAX + 1, 10, 100);
        send_reading(0, 0, 0);
        send_reading(10, 5, 100);
        send_reading(3, 1, 100);
        send_reading(VALID_MAX, 1, VALID_MAX);
        send_reading(1, VALID_MAX, VALID_MAX);
        send_reading(0, 100, 100);
        send_reading(100, 100, 14);
        send_reading(100, 0, 100);
        send_reading(100, 100, 15);
        send_reading(100, 100, 0);
        send_reading(1, 1, 1);
        send_reading(100, 300, 100);
        send_reading(200, 40, 200);
        send_reading(100, 100, DIST_MAX);
        send_reading(16'h8000, 16'h4000, 16'h2000);
        send_reading(16'h7fff, 16'h00ff, 16'h0001);
    endtask

    // register extremes, zero period, both sides low, unused indexes
    task automatic test_register_extremes();
        apply_config(PERIOD_MAX, 0, REG_MAX, REG_MAX, 200);
        repeat (12) send_random_reading();

        apply_config(1, REG_MAX, 0, 0, 0);
        repeat (8) send_random_reading();

        apply_config(0, 15, 10, 0, REG_MAX);
        send_reading(3, 4, 100);
        send_reading(4, 4, 100);
        send_reading(9, 2, 100);
        send_reading(10, 1, 100);
        repeat (6) send_random_reading();

        apply_config(PERIOD_RST, 0, 0, 0, REG_MAX);
        send_reading(1, VALID_MAX, VALID_MAX);
        send_reading(VALID_MAX, 1, VALID_MAX);
        repeat (6) send_random_reading();

        // writes to unused indexes must leave every register alone
        wait_drained();
        for (int unsigned idx = int'(REG_CENTER) + 1; idx < (1 << REG_IDX_W); idx++)
            write_reg(REG_IDX_W'(idx), PERIOD_WIDTH'(PERIOD_MAX));
        repeat (8) send_random_reading();
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        apply_config(PERIOD_RST, STOP_RST, LOW_RST, TRIM_RST, CENTER_RST);
        steady_mode = 1'b1;
        repeat (100) send_random_reading();
        wait_drained();
        steady_mode = 1'b0;
    endtask

    // random register settings, each followed by a batch of readings
    task automatic test_random_phases();
        int unsigned period;
        int unsigned stop;
        int unsigned low;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       period = 1;
                1:       period = PERIOD_MAX;
                2:       period = PERIOD_RST;
                3:       period = $urandom_range(1, 1000);
                default: period = $urandom_range(1, PERIOD_MAX);
            endcase
            stop = ($urandom_range(0, 9) == 0) ? REG_MAX : $urandom_range(0, 40);
            low  = ($urandom_range(0, 9) == 0) ? REG_MAX : $urandom_range(0, 40);
            apply_config(period, stop, low,
                         ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, REG_MAX),
                         $urandom_range(0, 200));
            repeat (PHASE_ITEMS) send_random_reading();
        end
    endtask

    // result sink ready with random stalls
    initial
    begin
        int unsigned stall_left;
        stall_left     = 0;
        steer_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (steady_mode)
                steer_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                steer_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                steer_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = rand_gap();
            end
        end
    end

    // check each steering beat against the oldest prediction
    always @(posedge clk)
    begin
        steer_beat_t want;
        if (rst_n && steer_ch.valid && steer_ch.ready)
        begin
            if (pending_steer.size() == 0)
                report_mismatch($sformatf("unexpected steer beat compare %0d",
                                          steer_ch.servo_compare));
            else
            begin
                want = pending_steer.pop_front();
                if (steer_ch.servo_compare !== want.servo_compare)
                    report_mismatch($sformatf("servo_compare got %0d expected %0d",
                                              steer_ch.servo_compare, want.servo_compare));
                if (steer_ch.drive_forward !== want.drive_forward)
                    report_mismatch($sformatf("drive_forward got %b expected %b",
                                              steer_ch.drive_forward, want.drive_forward));
                if (steer_ch.fault !== want.fault)
                    report_mismatch($sformatf("fault got %b expected %b",
                                              steer_ch.fault, want.fault));
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (sonar_ch.valid && sonar_ch.ready) || (steer_ch.valid && steer_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("obstacle_steering_controller_core_tb: FAIL");
            $finish;
        end
    end

    // reset, test sequence, final verdict
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = REG_PWM_PERIOD;
        cfg_data                = '0;
        sonar_ch.valid          = 1'b0;
        sonar_ch.left_distance  = '0;
        sonar_ch.right_distance = '0;
        sonar_ch.front_distance = '0;
        period_reg              = PERIOD_RST;
        stop_reg                = STOP_RST;
        side_low_reg            = LOW_RST;
        trim_reg                = TRIM_RST;
        center_reg              = CENTER_RST;
        armed                   = 1'b0;
        mismatch_count          = 0;
        idle_cycles             = 0;
        steady_mode             = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_back_to_back();
        test_random_phases();

        wait_drained();
        if (mismatch_count == 0)
            $display("obstacle_steering_controller_core_tb: PASS");
        else
            $display("obstacle_steering_controller_core_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/osc_pkg.sv
rtl/osc_if.sv
rtl/osc_div.sv
rtl/osc_cfg.sv
rtl/obstacle_steering_controller_core.sv
rtl/osc_checker.sv
dv/obstacle_steering_controller_core_tb.sv
